[rtl/hut_pkg.sv]
package hut_pkg;

  localparam int TableEntries = 32;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int MaxSends     = 4;
  localparam int NameChars    = 9;
  localparam int PackChars    = 9;
  localparam int CallW        = 7 * PackChars;
  localparam int PenW         = 6;

  localparam logic [1:0] CMD_HEARD = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_SFX   = 2'd2;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_XMIT = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;
  localparam logic [1:0] KIND_SFX  = 2'd3;

  localparam logic [2:0] REG_NUM_XMITS   = 3'd0;
  localparam logic [2:0] REG_XMIT_DELAYS = 3'd1;
  localparam logic [2:0] REG_RETAIN      = 3'd2;
  localparam logic [2:0] REG_DEF_OVERLAY = 3'd3;
  localparam logic [2:0] REG_DEF_SYMBOL  = 3'd4;

  typedef struct packed {
    logic             valid;
    logic [CallW-1:0] call;
    logic [3:0]       len;
    logic [7:0]       overlay;
    logic [7:0]       symbol;
    logic [15:0]      count;
    logic [31:0]      heard_at;
    logic [2:0]       sent;
    logic [31:0]      next_send;
    logic [PenW-1:0]  pen;
  } entry_t;

  typedef struct packed {
    logic [5:0]       purged;
    logic [3:0]       mlen;
    logic [CallW-1:0] mcall;
    logic [PenW-1:0]  pen;
    logic [15:0]      count;
    logic             new_entry;
    logic             found;
    logic [IdxW-1:0]  idx;
    logic             error;
    logic [1:0]       kind;
    logic             last;
  } result_t;

  function automatic logic [CallW-1:0] keep_chars(input logic [CallW-1:0] call,
                                                  input logic [3:0] len);
    logic [CallW-1:0] m;
    m = '0;
    for (int k = 0; k < PackChars; k++) begin
      if (k < int'(len)) begin
        m[CallW-1-7*k -: 7] = 7'h7f;
      end
    end
    return call & m;
  endfunction

endpackage

[rtl/hut_cell.sv]
module hut_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  hut_pkg::entry_t d,
  output hut_pkg::entry_t q
);
  import hut_pkg::*;

  entry_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else if (shift) begin
      ent_r.valid <= d.valid;
    end
    if (shift) begin
      ent_r.call      <= d.call;
      ent_r.len       <= d.len;
      ent_r.overlay   <= d.overlay;
      ent_r.symbol    <= d.symbol;
      ent_r.count     <= d.count;
      ent_r.heard_at  <= d.heard_at;
      ent_r.sent      <= d.sent;
      ent_r.next_send <= d.next_send;
      ent_r.pen       <= d.pen;
    end
  end

  assign q = ent_r;

endmodule

[rtl/heard_user_table_scheduler.sv]
// A heard beat makes two or three passes of the entry ring (three when a new user needs a
// pen slot) and then emits its result; a heard beat without a callsign goes straight to the
// emit, and a tick or lookup makes one pass and then emits, each held by any output stalls.
// One beat is in work at a time; the rate is set by the 32-cell ring, which turns once per
// pass. Reset (synchronous, rst_n low) empties the table, zeroes the seconds counter and loads
// the register defaults; no clearing pass is needed.
module heard_user_table_scheduler (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // callsign, callsign_length, overlay, symbol, position_known, suffix, zero pad
  input  logic [111:0]  in_tdata,
  // command
  input  logic [1:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // error, entry_index, found, new_entry, heard_count, pen_slot, matched_callsign,
  // matched_length, purged_count, zero pad
  output logic [103:0]  out_tdata,
  // kind
  output logic [1:0]    out_tuser,
  output logic          out_tlast,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [63:0]   cfg_wdata
);
  import hut_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MASK  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_TICK  = 3'd4;
  localparam logic [2:0] S_SFX   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  logic [2:0]  nx_r;
  logic [63:0] delays_r;
  logic [15:0] retain_r;
  logic [7:0]  dov_r, dsy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r     <= 3'd3;
      delays_r <= 64'h000D000000050005;
      retain_r <= 16'd4800;
      dov_r    <= 8'd65;
      dsy_r    <= 8'd65;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NUM_XMITS:   nx_r     <= cfg_wdata[2:0];
        REG_XMIT_DELAYS: delays_r <= cfg_wdata;
        REG_RETAIN:      retain_r <= cfg_wdata[15:0];
        REG_DEF_OVERLAY: dov_r    <= cfg_wdata[7:0];
        REG_DEF_SYMBOL:  dsy_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  entry_t cell_q [TableEntries];
  entry_t head, tail;
  logic   shift;

  assign head = cell_q[0];

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    if (g == TableEntries - 1) begin : g_end
      hut_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .d(tail), .q(cell_q[g]));
    end else begin : g_mid
      hut_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .d(cell_q[g+1]),
                       .q(cell_q[g]));
    end
  end

  logic [2:0]       state_r, state_nxt;
  logic [IdxW-1:0]  cnt_r, cnt_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [CallW-1:0] call_r, call_nxt;
  logic [3:0]       len_r, len_nxt;
  logic [7:0]       ov_r, ov_nxt, sy_r, sy_nxt;
  logic             pos_r, pos_nxt;
  logic [20:0]      sfx_r, sfx_nxt;
  logic             err_r, err_nxt;
  logic             found_r, found_nxt;
  logic [IdxW-1:0]  idx_r, idx_nxt;
  logic             got_r, got_nxt;
  logic [IdxW-1:0]  free_r, free_nxt;
  logic [IdxW-1:0]  lru_r, lru_nxt;
  logic [31:0]      lru_last_r, lru_last_nxt;
  logic [TableEntries-1:0] used_r, used_nxt;
  logic [PenW-1:0]  pen_new_r, pen_new_nxt;
  logic [15:0]      res_cnt_r, res_cnt_nxt;
  logic [PenW-1:0]  res_pen_r, res_pen_nxt;
  logic [5:0]       purged_r, purged_nxt;
  logic             sf_found_r, sf_found_nxt;
  logic [IdxW-1:0]  sf_idx_r, sf_idx_nxt;
  logic [CallW-1:0] sf_call_r, sf_call_nxt;
  logic [3:0]       sf_len_r, sf_len_nxt;
  logic [31:0]      sec_r, sec_nxt;

  result_t out_r, out_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    out_free, emit_req;
  result_t emit_res;

  logic        in_go, last_step, step;
  logic [3:0]  len_in;
  logic [2:0]  lim;
  logic        due, purge, sfx_hit;
  logic [2:0]  sent_inc;
  logic [20:0] tail_chars;
  logic [PenW-1:0] pen_low;

  assign in_tready = (state_r == S_IDLE);
  assign in_go     = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign len_in    = (in_tdata[66:63] > 4'(NameChars)) ? 4'(NameChars) : in_tdata[66:63];
  assign lim       = (nx_r > 3'(MaxSends)) ? 3'(MaxSends) : nx_r;
  assign sent_inc  = head.sent + 3'd1;
  assign due       = head.valid && (head.sent < lim) && (head.next_send <= sec_r);
  assign purge     = head.valid &&
                     (({1'b0, head.heard_at} + 33'(retain_r)) < {1'b0, sec_r});

  always_comb begin
    case (head.len)
      4'd3:    tail_chars = head.call[62:42];
      4'd4:    tail_chars = head.call[55:35];
      4'd5:    tail_chars = head.call[48:28];
      4'd6:    tail_chars = head.call[41:21];
      default: tail_chars = '0;
    endcase
  end
  assign sfx_hit = head.valid && (head.len >= 4'd3) && (head.len <= 4'd6) &&
                   (tail_chars == sfx_r);

  always_comb begin
    pen_low = PenW'(TableEntries);
    for (int s = TableEntries - 1; s >= 0; s--) begin
      if (!used_nxt[s]) pen_low = PenW'(s + 1);
    end
  end

  assign step = !(state_r == S_TICK && due && !out_free);
  assign shift = step && (state_r == S_SCAN || state_r == S_MASK || state_r == S_WRITE ||
                          state_r == S_TICK || state_r == S_SFX);
  assign last_step = shift && (cnt_r == LastIdx);

  always_comb begin
    state_nxt = state_r;  cnt_nxt = cnt_r;  cmd_nxt = cmd_r;
    call_nxt = call_r;  len_nxt = len_r;  ov_nxt = ov_r;  sy_nxt = sy_r;
    pos_nxt = pos_r;  sfx_nxt = sfx_r;  err_nxt = err_r;
    found_nxt = found_r;  idx_nxt = idx_r;  got_nxt = got_r;  free_nxt = free_r;
    lru_nxt = lru_r;  lru_last_nxt = lru_last_r;  used_nxt = used_r;
    pen_new_nxt = pen_new_r;  res_cnt_nxt = res_cnt_r;  res_pen_nxt = res_pen_r;
    purged_nxt = purged_r;  sf_found_nxt = sf_found_r;  sf_idx_nxt = sf_idx_r;
    sf_call_nxt = sf_call_r;  sf_len_nxt = sf_len_r;  sec_nxt = sec_r;
    tail = head;
    emit_req = 1'b0;
    emit_res = '0;

    if (shift) cnt_nxt = cnt_r + IdxW'(1);

    case (state_r)
      S_IDLE: begin
        if (in_go) begin
          cmd_nxt      = in_tuser;
          len_nxt      = len_in;
          call_nxt     = keep_chars(in_tdata[62:0], len_in);
          ov_nxt       = in_tdata[74:67];
          sy_nxt       = in_tdata[82:75];
          pos_nxt      = in_tdata[83];
          sfx_nxt      = in_tdata[104:84];
          cnt_nxt      = '0;
          err_nxt      = 1'b0;
          found_nxt    = 1'b0;
          got_nxt      = 1'b0;
          used_nxt     = '0;
          purged_nxt   = '0;
          sf_found_nxt = 1'b0;
          case (in_tuser)
            CMD_HEARD: begin
              if (len_in == 4'd0) begin
                err_nxt   = 1'b1;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_TICK: begin
              sec_nxt   = sec_r + 32'd1;
              state_nxt = S_TICK;
            end
            CMD_SFX: state_nxt = S_SFX;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (!found_r && head.valid && head.call == call_r && head.len == len_r &&
            head.overlay == ov_r) begin
          found_nxt = 1'b1;
          idx_nxt   = cnt_r;
        end
        if (!got_r && !head.valid) begin
          got_nxt  = 1'b1;
          free_nxt = cnt_r;
        end
        if (cnt_r == '0 || head.heard_at < lru_last_r) begin
          lru_nxt      = cnt_r;
          lru_last_nxt = head.heard_at;
        end
        if (last_step) begin
          if (!found_nxt) idx_nxt = got_nxt ? free_nxt : lru_nxt;
          state_nxt = (!found_nxt && !pos_r) ? S_MASK : S_WRITE;
        end
      end
      S_MASK: begin
        if (head.valid && cnt_r != idx_r && head.pen != '0) begin
          used_nxt[IdxW'(head.pen - PenW'(1))] = 1'b1;
        end
        if (last_step) begin
          pen_new_nxt = pen_low;
          state_nxt   = S_WRITE;
        end
      end
      S_WRITE: begin
        if (cnt_r == idx_r) begin
          if (found_r) begin
            if (head.count != 16'hFFFF) tail.count = head.count + 16'd1;
            if (ov_r != dov_r || sy_r != dsy_r) begin
              tail.overlay = ov_r;
              tail.symbol  = sy_r;
            end
            if (pos_r) tail.pen = '0;
          end else begin
            tail.valid   = 1'b1;
            tail.call    = call_r;
            tail.len     = len_r;
            tail.overlay = ov_r;
            tail.symbol  = sy_r;
            tail.count   = 16'd1;
            tail.pen     = pos_r ? '0 : pen_new_r;
          end
          tail.heard_at  = sec_r;
          tail.sent      = '0;
          tail.next_send = sec_r + 32'(delays_r[15:0]);
          res_cnt_nxt    = tail.count;
          res_pen_nxt    = tail.pen;
        end
        if (last_step) state_nxt = S_EMIT;
      end
      S_TICK: begin
        if (due) begin
          emit_req       = 1'b1;
          emit_res.kind  = KIND_XMIT;
          emit_res.idx   = cnt_r;
          emit_res.count = head.count;
          emit_res.pen   = head.pen;
          tail.sent      = sent_inc;
          if (sent_inc < lim) begin
            tail.next_send = head.next_send + 32'(delays_r[16*sent_inc[1:0] +: 16]);
          end
        end
        if (purge) begin
          tail.valid = 1'b0;
          if (step) purged_nxt = purged_r + 6'd1;
        end
        if (last_step) state_nxt = S_EMIT;
      end
      S_SFX: begin
        if (!sf_found_r && sfx_hit) begin
          sf_found_nxt = 1'b1;
          sf_idx_nxt   = cnt_r;
          sf_call_nxt  = head.call;
          sf_len_nxt   = head.len;
        end
        if (last_step) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        emit_req      = 1'b1;
        emit_res.last = 1'b1;
        case (cmd_r)
          CMD_HEARD: begin
            emit_res.kind = KIND_ACK;
            if (err_r) begin
              emit_res.error = 1'b1;
            end else begin
              emit_res.idx       = idx_r;
              emit_res.found     = found_r;
              emit_res.new_entry = !found_r;
              emit_res.count     = res_cnt_r;
              emit_res.pen       = res_pen_r;
            end
          end
          CMD_TICK: begin
            emit_res.kind   = KIND_TICK;
            emit_res.purged = purged_r;
          end
          default: begin
            emit_res.kind = KIND_SFX;
            if (sf_found_r) begin
              emit_res.found = 1'b1;
              emit_res.idx   = sf_idx_r;
              emit_res.mcall = sf_call_r;
              emit_res.mlen  = sf_len_r;
            end
          end
        endcase
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = emit_req;
      if (emit_req) out_nxt = emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;      call_r     <= call_nxt;     len_r    <= len_nxt;
    ov_r       <= ov_nxt;       sy_r       <= sy_nxt;       pos_r    <= pos_nxt;
    sfx_r      <= sfx_nxt;      err_r      <= err_nxt;      found_r  <= found_nxt;
    idx_r      <= idx_nxt;      got_r      <= got_nxt;      free_r   <= free_nxt;
    lru_r      <= lru_nxt;      lru_last_r <= lru_last_nxt; used_r   <= used_nxt;
    pen_new_r  <= pen_new_nxt;  res_cnt_r  <= res_cnt_nxt;  res_pen_r <= res_pen_nxt;
    purged_r   <= purged_nxt;   sf_found_r <= sf_found_nxt; sf_idx_r <= sf_idx_nxt;
    sf_call_r  <= sf_call_nxt;  sf_len_r   <= sf_len_nxt;   out_r    <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {1'b0, out_r.purged, out_r.mlen, out_r.mcall, out_r.pen, out_r.count,
                       out_r.new_entry, out_r.found, out_r.idx, out_r.error};

endmodule
